[hw/rtl/gbvs_pkg.sv]
`default_nettype none
package gbvs_pkg;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_SHAPE = 2'd1;
  localparam logic [1:0] REQ_VEL   = 2'd2;
  localparam logic [1:0] REQ_QUERY = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_SAT     = 2'd2;
  localparam logic [1:0] STAT_NOSHAPE = 2'd3;

  // quotient bits of one half term, a term of 2^20 or more is out of range
  localparam int QBITS = 20;
  localparam int SUM_W = 40;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic               fail;
    logic signed [15:0] intensity;
  } item_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/gbvs_div_cell.sv]
`default_nettype none
module gbvs_div_cell #(
  parameter int REM_W = 55,
  parameter int BIT   = 0
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire gbvs_pkg::item_ctl_t                   ctl_i,
  input  wire logic [2:0][REM_W-1:0]                 rem_i,
  input  wire logic [2:0][31:0]                      den_i,
  input  wire logic [2:0][gbvs_pkg::QBITS-1:0]       quo_i,
  output gbvs_pkg::item_ctl_t                        ctl_o,
  output logic [2:0][REM_W-1:0]                      rem_o,
  output logic [2:0][31:0]                           den_o,
  output logic [2:0][gbvs_pkg::QBITS-1:0]            quo_o
);
  import gbvs_pkg::*;

  item_ctl_t               ctl_r;
  logic [2:0][REM_W-1:0]   rem_r, rem_nxt;
  logic [2:0][31:0]        den_r;
  logic [2:0][QBITS-1:0]   quo_r, quo_nxt;
  logic [2:0][REM_W-1:0]   trial;

  // one restoring division step per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      trial[a]   = REM_W'(den_i[a]) << BIT;
      rem_nxt[a] = rem_i[a];
      quo_nxt[a] = quo_i[a];
      if (rem_i[a] >= trial[a]) begin
        rem_nxt[a] = rem_i[a] - trial[a];
        quo_nxt[a] = quo_i[a] | (QBITS'(1) << BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_i;
    quo_r <= quo_nxt;
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign den_o = den_r;
  assign quo_o = quo_r;

endmodule
`default_nettype wire

[hw/rtl/gbvs_exp_rom.sv]
`default_nettype none
module gbvs_exp_rom #(
  parameter int TABLE_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic [TABLE_BITS-1:0] idx_i,
  output logic [15:0]                factor_o
);

  localparam int SIZE = 1 << TABLE_BITS;

  function automatic logic [SIZE*16-1:0] build_table();
    logic [63:0]        t;
    logic signed [63:0] s;
    logic [63:0]        q;
    logic [64:0]        acc;
    logic [64:0]        r;
    logic [127:0]       prod;
    logic [SIZE*16-1:0] tab;
    logic [63:0]        num;
    logic [63:0]        quo;
    logic [63:0]        rem;
    t = 64'd1 << 32;
    s = 64'sd4294967296;
    for (int n = 1; n <= 30; n++) begin
      // long division of the shifted term by n
      num = t >> (TABLE_BITS - 4);
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= 64'(n)) begin
          rem    = rem - 64'(n);
          quo[b] = 1'b1;
        end
      end
      t = quo;
      if (n[0]) s = s - $signed(t);
      else s = s + $signed(t);
    end
    q = s;
    acc = 65'd1 << 32;
    for (int k = 0; k < SIZE; k++) begin
      r = (acc + 65'd32768) >> 16;
      tab[k*16 +: 16] = (r > 65'd65535) ? 16'hFFFF : r[15:0];
      prod = {63'd0, acc} * {64'd0, q} + 128'h8000_0000;
      acc = prod[96:32];
    end
    return tab;
  endfunction

  localparam logic [SIZE*16-1:0] TAB = build_table();

  logic [15:0] factor_r;

  always_ff @(posedge clk) begin
    factor_r <= TAB[idx_i*16 +: 16];
  end

  assign factor_o = factor_r;

endmodule
`default_nettype wire

[hw/rtl/moving_gaussian_blob_voxel_sum.sv]
// channel  | ports                                     | handshake
// ---------+-------------------------------------------+----------------------------
// input    | in_req_type, in_intensity, in_sig_*,      | taken when start && !busy
//          | in_vec_*, in_frame                        |
// result   | out_sum_value, out_status                 | out_valid, one cycle, no stall
//
// clear, shape and velocity items give their result in the cycle after acceptance
// and leave busy low. a query over N stored particles streams them one per cycle
// from the particle memory, through its single read port, into a chain of 20
// division cells, and busy stays high until its result.
// reset is synchronous and empties the table. results cannot be stalled.
`default_nettype none
module moving_gaussian_blob_voxel_sum #(
  parameter int MAX_PARTICLES   = 64,
  parameter int EXP_TABLE_BITS  = 8,
  parameter int COORD_FRAC_BITS = 6
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_req_type,
  input  wire logic signed [15:0] in_intensity,
  input  wire logic [15:0]        in_sig_x,
  input  wire logic [15:0]        in_sig_y,
  input  wire logic [15:0]        in_sig_z,
  input  wire logic signed [15:0] in_vec_x,
  input  wire logic signed [15:0] in_vec_y,
  input  wire logic signed [15:0] in_vec_z,
  input  wire logic [15:0]        in_frame,
  output logic                    out_valid,
  output logic signed [39:0]      out_sum_value,
  output logic [1:0]              out_status
);
  import gbvs_pkg::*;

  localparam int CW     = $clog2(MAX_PARTICLES + 1);
  localparam int AW     = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int NUM_SH = 31 - 2 * COORD_FRAC_BITS;
  localparam int REM_W  = 48 + NUM_SH;
  localparam int ACC_W  = 32 + CW;
  localparam int SW     = (ACC_W > SUM_W) ? ACC_W : SUM_W;
  localparam logic signed [SW-1:0] SAT_HI = $signed(SW'({1'b0, {(SUM_W-1){1'b1}}}));
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [15:0]         frame_r;
  logic [2:0][15:0]    cvec_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, acc_sum;
  logic                out_valid_r, out_valid_nxt;
  logic signed [39:0]  out_sum_r, out_sum_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic signed [SW-1:0] acc_ext;

  logic                accept, issue, issue_last;
  logic                shape_we, vel_we;
  logic [AW-1:0]       wr_addr;

  logic [111:0]        shape_mem [MAX_PARTICLES];
  logic [47:0]         vel_mem [MAX_PARTICLES];
  logic [111:0]        shape_rd_r;
  logic [47:0]         vel_rd_r;
  logic                s0_valid_r, s0_last_r;

  item_ctl_t                 ctl1_r, ctl2_r, ctl3_r, ctlA_r, ctlB_r, ctlC_r;
  logic signed [2:0][32:0]   prod1_r;
  logic [2:0][15:0]          start1_r, sig1_r, sig2_r;
  logic [2:0][34:0]          ad2_r;
  logic [2:0][47:0]          sq3_r;
  logic [2:0][31:0]          den3_r;
  logic [15:0]               factor;
  logic [EXP_TABLE_BITS-1:0] idxA_r;
  logic signed [32:0]        contribC_r;

  item_ctl_t                 c_ctl [QBITS+1];
  logic [2:0][REM_W-1:0]     c_rem [QBITS+1];
  logic [2:0][31:0]          c_den [QBITS+1];
  logic [2:0][QBITS-1:0]     c_quo [QBITS+1];

  assign accept     = start && !busy;
  assign busy       = (state_r != S_IDLE);
  assign issue      = (state_r == S_ISSUE);
  assign issue_last = (rd_idx_r == cnt_r - CW'(1));
  assign wr_addr    = cnt_r[AW-1:0];
  assign shape_we   = accept && in_req_type == REQ_SHAPE && cnt_r < CW'(MAX_PARTICLES);
  assign vel_we     = accept && in_req_type == REQ_VEL && pend_r
                      && cnt_r < CW'(MAX_PARTICLES);

  // particle memories
  always_ff @(posedge clk) begin
    if (shape_we) begin
      shape_mem[wr_addr] <= {in_intensity, in_sig_z, in_sig_y, in_sig_x,
                             in_vec_z, in_vec_y, in_vec_x};
    end
    if (vel_we) begin
      vel_mem[wr_addr] <= {in_vec_z, in_vec_y, in_vec_x};
    end
    shape_rd_r <= shape_mem[rd_idx_r[AW-1:0]];
    vel_rd_r   <= vel_mem[rd_idx_r[AW-1:0]];
  end

  // front pipeline: position, distance, squares
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      prod1_r[a]  <= $signed({1'b0, frame_r}) * $signed(vel_rd_r[a*16 +: 16]);
      start1_r[a] <= shape_rd_r[a*16 +: 16];
      sig1_r[a]   <= shape_rd_r[48 + a*16 +: 16];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      logic signed [34:0] d;
      d = 35'($signed(cvec_r[a]))
          - (35'($signed(start1_r[a])) + 35'($signed(prod1_r[a])));
      ad2_r[a]  <= d[34] ? 35'(-d) : d;
      sig2_r[a] <= sig1_r[a];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      sq3_r[a]  <= ad2_r[a][23:0] * ad2_r[a][23:0];
      den3_r[a] <= sig2_r[a] * sig2_r[a];
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      c_rem[0][a] <= {sq3_r[a], {NUM_SH{1'b0}}};
      c_den[0][a] <= den3_r[a];
      c_quo[0][a] <= '0;
    end
  end

  // control along the front pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r    <= 1'b0;
      ctl1_r.valid  <= 1'b0;
      ctl2_r.valid  <= 1'b0;
      ctl3_r.valid  <= 1'b0;
      c_ctl[0].valid <= 1'b0;
    end else begin
      s0_valid_r <= issue;
      s0_last_r  <= issue_last;
      ctl1_r     <= '{valid: s0_valid_r, last: s0_last_r, fail: 1'b0,
                      intensity: $signed(shape_rd_r[111:96])};
      ctl2_r     <= ctl1_r;
      ctl3_r     <= '{valid: ctl2_r.valid, last: ctl2_r.last,
                      fail: (ad2_r[0][34:24] != '0) || (ad2_r[1][34:24] != '0)
                            || (ad2_r[2][34:24] != '0) || (sig2_r[0] == '0)
                            || (sig2_r[1] == '0) || (sig2_r[2] == '0),
                      intensity: ctl2_r.intensity};
      c_ctl[0]   <= '{valid: ctl3_r.valid, last: ctl3_r.last,
                      fail: ctl3_r.fail
          || ({sq3_r[0], {NUM_SH{1'b0}}} >= (REM_W'(den3_r[0]) << QBITS))
          || ({sq3_r[1], {NUM_SH{1'b0}}} >= (REM_W'(den3_r[1]) << QBITS))
          || ({sq3_r[2], {NUM_SH{1'b0}}} >= (REM_W'(den3_r[2]) << QBITS)),
                      intensity: ctl3_r.intensity};
    end
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    gbvs_div_cell #(
      .REM_W (REM_W),
      .BIT   (QBITS - 1 - i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (c_ctl[i]),
      .rem_i (c_rem[i]),
      .den_i (c_den[i]),
      .quo_i (c_quo[i]),
      .ctl_o (c_ctl[i+1]),
      .rem_o (c_rem[i+1]),
      .den_o (c_den[i+1]),
      .quo_o (c_quo[i+1])
    );
  end

  // argument, table lookup, product
  logic [QBITS+1:0] arg;
  assign arg = (QBITS+2)'(c_quo[QBITS][0]) + (QBITS+2)'(c_quo[QBITS][1])
             + (QBITS+2)'(c_quo[QBITS][2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctlA_r.valid <= 1'b0;
      ctlB_r.valid <= 1'b0;
      ctlC_r.valid <= 1'b0;
    end else begin
      ctlA_r      <= '{valid: c_ctl[QBITS].valid, last: c_ctl[QBITS].last,
                       fail: c_ctl[QBITS].fail || (arg[QBITS+1:QBITS] != '0),
                       intensity: c_ctl[QBITS].intensity};
      ctlB_r      <= ctlA_r;
      ctlC_r      <= ctlB_r;
    end
  end

  always_ff @(posedge clk) begin
    idxA_r     <= arg[QBITS-1 -: EXP_TABLE_BITS];
    contribC_r <= ctlB_r.fail ? 33'sd0 : ctlB_r.intensity * $signed({1'b0, factor});
  end

  gbvs_exp_rom #(
    .TABLE_BITS (EXP_TABLE_BITS)
  ) u_rom (
    .clk      (clk),
    .idx_i    (idxA_r),
    .factor_o (factor)
  );

  assign acc_sum = acc_r + ACC_W'(contribC_r);
  assign acc_ext = SW'(acc_sum);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    rd_idx_nxt     = rd_idx_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = 1'b0;
    out_sum_nxt    = '0;
    out_status_nxt = STAT_OK;
    if (accept) begin
      unique case (in_req_type)
        REQ_CLEAR: begin
          cnt_nxt       = '0;
          pend_nxt      = 1'b0;
          out_valid_nxt = 1'b1;
        end
        REQ_SHAPE: begin
          out_valid_nxt = 1'b1;
          if (cnt_r >= CW'(MAX_PARTICLES)) begin
            pend_nxt       = 1'b0;
            out_status_nxt = STAT_FULL;
          end else begin
            pend_nxt = 1'b1;
          end
        end
        REQ_VEL: begin
          out_valid_nxt = 1'b1;
          if (vel_we) begin
            cnt_nxt  = cnt_r + CW'(1);
            pend_nxt = 1'b0;
          end else begin
            out_status_nxt = STAT_NOSHAPE;
          end
        end
        REQ_QUERY: begin
          acc_nxt    = '0;
          rd_idx_nxt = '0;
          if (cnt_r == '0) begin
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
        default: ;
      endcase
    end
    if (issue) begin
      rd_idx_nxt = rd_idx_r + CW'(1);
      if (issue_last) state_nxt = S_DRAIN;
    end
    if (ctlC_r.valid) begin
      acc_nxt = acc_sum;
      if (ctlC_r.last) begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        priority if (acc_ext > SAT_HI) begin
          out_sum_nxt    = SAT_HI[39:0];
          out_status_nxt = STAT_SAT;
        end else if (acc_ext < SAT_LO) begin
          out_sum_nxt    = SAT_LO[39:0];
          out_status_nxt = STAT_SAT;
        end else begin
          out_sum_nxt = acc_ext[39:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    out_sum_r    <= out_sum_nxt;
    out_status_r <= out_status_nxt;
    if (accept && in_req_type == REQ_QUERY) begin
      frame_r   <= in_frame;
      cvec_r[0] <= in_vec_x;
      cvec_r[1] <= in_vec_y;
      cvec_r[2] <= in_vec_z;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sum_value = out_sum_r;
  assign out_status    = out_status_r;

`ifndef SYNTHESIS
  a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req_type == REQ_QUERY && cnt_r == '0 |=> out_valid && !busy)
    else $error("empty query gave no result");
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctlC_r.valid && ctlC_r.last |=> out_valid && !busy)
    else $error("last particle did not finish the query");
  a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> rd_idx_r < cnt_r)
    else $error("particle read past the table");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_PARTICLES))
    else $error("particle count overflow");
`endif

endmodule
`default_nettype wire
